// ----- sv/ppc_pkg.sv -----
package ppc_pkg;

  localparam int CFG_W   = 5;
  localparam int PDATA_W = 32;
  localparam int PADDR_W = 3;

  localparam logic REG_MAX_EXP = 1'b0;

  typedef struct packed {
    logic load;
    logic start_exp;
    logic mul;
    logic record;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic trial_end;
    logic bit_last;
    logic exp_last;
    logic out_busy;
  } stat_t;

endpackage

// ----- sv/ppc_ctrl.sv -----
module ppc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  ppc_pkg::stat_t stat,
  output ppc_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_START  = 3'd2;
  localparam logic [2:0] S_MUL    = 3'd3;
  localparam logic [2:0] S_EXPEND = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.skip) begin
          state_nxt = S_OUT;
        end else begin
          cmd.start_exp = 1'b1;
          state_nxt     = S_MUL;
        end
      end
      S_START: begin
        cmd.start_exp = 1'b1;
        state_nxt     = S_MUL;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        if (stat.trial_end && stat.bit_last) begin
          state_nxt = S_EXPEND;
        end
      end
      S_EXPEND: begin
        cmd.record = 1'b1;
        state_nxt  = stat.exp_last ? S_OUT : S_START;
      end
      S_OUT: begin
        if (!stat.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- sv/ppc_datapath.sv -----
module ppc_datapath #(
  parameter int DATA_WIDTH    = 32,
  parameter int MAX_EXP_LIMIT = 31
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic signed [DATA_WIDTH-1:0]  in_value,
  input  logic [ppc_pkg::CFG_W-1:0]     max_exp,
  input  ppc_pkg::cmd_t                 cmd,
  output ppc_pkg::stat_t                stat,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [MAX_EXP_LIMIT-2:0]      out_power_mask
);

  localparam int AW = DATA_WIDTH - 1;
  localparam int RB = DATA_WIDTH / 2;
  localparam int PW = AW + RB;
  localparam int KW = $clog2(MAX_EXP_LIMIT + 1);
  localparam int MW = MAX_EXP_LIMIT - 1;

  logic [RB-1:0] sb_tab [0:MAX_EXP_LIMIT];

  for (genvar g = 0; g <= MAX_EXP_LIMIT; g++) begin : g_sb
    if (g < 2) begin : g_unused
      assign sb_tab[g] = '0;
    end else begin : g_used
      localparam int SB = (DATA_WIDTH - 1 + g - 1) / g;
      assign sb_tab[g] = RB'(1) << (SB - 1);
    end
  end

  logic [AW-1:0] v_r;
  logic          pos_r;
  logic [KW-1:0] k_r;
  logic [KW-1:0] cnt_r;
  logic [RB-1:0] root_r;
  logic [RB-1:0] bit_r;
  logic [AW-1:0] acc_r;
  logic          eq_r;
  logic [MW-1:0] mask_r;
  logic          out_valid_r;
  logic [MW-1:0] out_mask_r;

  logic [RB-1:0] cand;
  logic [PW-1:0] prod;
  logic          over;
  logic          last_mul;

  assign cand     = root_r | bit_r;
  assign prod     = PW'(acc_r) * PW'(cand);
  assign over     = prod > PW'(v_r);
  assign last_mul = (cnt_r == k_r - KW'(1));

  assign stat.skip      = !pos_r || (max_exp < ppc_pkg::CFG_W'(2));
  assign stat.trial_end = over || last_mul;
  assign stat.bit_last  = bit_r[0];
  assign stat.exp_last  = (k_r >= KW'(max_exp));
  assign stat.out_busy  = out_valid_r && out_stall;

  assign out_valid      = out_valid_r;
  assign out_power_mask = out_mask_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v_r    <= in_value[AW-1:0];
      pos_r  <= !in_value[DATA_WIDTH-1] && (in_value != '0);
      mask_r <= '0;
      k_r    <= KW'(2);
    end
    if (cmd.start_exp) begin
      root_r <= '0;
      bit_r  <= sb_tab[k_r];
      acc_r  <= AW'(1);
      cnt_r  <= '0;
      eq_r   <= 1'b0;
    end
    if (cmd.mul) begin
      if (over || last_mul) begin
        acc_r <= AW'(1);
        cnt_r <= '0;
        bit_r <= bit_r >> 1;
        if (!over) begin
          root_r <= cand;
          eq_r   <= (prod == PW'(v_r));
        end
      end else begin
        acc_r <= prod[AW-1:0];
        cnt_r <= cnt_r + KW'(1);
      end
    end
    if (cmd.record) begin
      mask_r <= mask_r | (MW'(eq_r) << (k_r - KW'(2)));
      k_r    <= k_r + KW'(1);
    end
    if (cmd.emit) begin
      out_mask_r <= mask_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

// ----- sv/perfect_power_classifier.sv -----
// Perfect power classifier.
// Input channel (in_valid, in_stall, in_value): one signed value per item.
// Output channel (out_valid, out_stall, out_power_mask): one mask per item;
// bit k-2 is set when the value is positive and an exact k-th power, for k
// from 2 up to max_exponent. Zero and negative values give an empty mask.
// Register max_exponent sits at byte address 0 of the APB port; writes
// above MAX_EXP_LIMIT saturate to it.
// One item is worked at a time. For each exponent k the integer k-th root
// is built one bit per trial, from bit ceil((DATA_WIDTH-1)/k)-1 down, and
// each trial raises the candidate to the k-th power through one shared
// multiplier, one multiply per cycle, stopping early once the power passes
// the value. Non-positive values and max_exponent below 2 skip the
// root search and go straight to the output. in_stall drops the cycle
// after the mask is handed to the output register, so a new item is not
// taken until the last one is finished.
// A stalled receiver holds one finished mask while the next item is accepted
// and worked; a second mask waits until the first is taken.
// Reset empties the output register, returns the controller to idle and
// sets max_exponent to 31, clamped to MAX_EXP_LIMIT.
module perfect_power_classifier #(
  parameter int DATA_WIDTH    = 32,
  parameter int MAX_EXP_LIMIT = 31
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [DATA_WIDTH-1:0]   in_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [MAX_EXP_LIMIT-2:0]       out_power_mask,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ppc_pkg::PADDR_W-1:0]    paddr,
  input  logic [ppc_pkg::PDATA_W-1:0]    pwdata,
  output logic [ppc_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready
);

  localparam logic [ppc_pkg::CFG_W-1:0] MAXE_RST =
    (MAX_EXP_LIMIT < 31) ? ppc_pkg::CFG_W'(MAX_EXP_LIMIT) : ppc_pkg::CFG_W'(31);

  logic [ppc_pkg::CFG_W-1:0] max_exp_r;
  logic [ppc_pkg::CFG_W-1:0] max_exp_nxt;
  logic [ppc_pkg::CFG_W-1:0] wr_exp;
  logic                      cfg_wr;

  ppc_pkg::cmd_t  cmd;
  ppc_pkg::stat_t stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == ppc_pkg::REG_MAX_EXP);
  assign wr_exp = pwdata[ppc_pkg::CFG_W-1:0];

  always_comb begin
    max_exp_nxt = max_exp_r;
    if (cfg_wr) begin
      max_exp_nxt = (int'(wr_exp) > MAX_EXP_LIMIT) ? ppc_pkg::CFG_W'(MAX_EXP_LIMIT) : wr_exp;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == ppc_pkg::REG_MAX_EXP) begin
      prdata = ppc_pkg::PDATA_W'(max_exp_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_exp_r <= MAXE_RST;
    end else begin
      max_exp_r <= max_exp_nxt;
    end
  end

  ppc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ppc_datapath #(
    .DATA_WIDTH    (DATA_WIDTH),
    .MAX_EXP_LIMIT (MAX_EXP_LIMIT)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_value       (in_value),
    .max_exp        (max_exp_r),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_power_mask (out_power_mask)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while an item is in progress");

  a_mask_limited: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_power_mask == '0) ||
                   ((max_exp_r >= ppc_pkg::CFG_W'(2)) &&
                    ((out_power_mask >> (max_exp_r - ppc_pkg::CFG_W'(1))) == '0))))
    else $error("mask bit set above the largest exponent");

  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid || !out_stall))
    else $error("result written over a waiting result");
`endif

endmodule
